@@ design/led_bar_pattern_sequencer_assert.svh @@
// Assertion macros of the LED bar pattern sequencer, included by its top level.
`ifndef LED_BAR_PATTERN_SEQUENCER_ASSERT_SVH
`define LED_BAR_PATTERN_SEQUENCER_ASSERT_SVH

`ifndef ASSERT_OFF
// Checks that a property holds at every clock edge outside reset.
`define LBPS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Checks that a condition in one cycle implies another in the next cycle.
`define LBPS_ASSERT_NEXT(lbl, cond, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |=> (cons)) \
    else $error(msg);
`else
`define LBPS_ASSERT(lbl, prop, msg)
`define LBPS_ASSERT_NEXT(lbl, cond, cons, msg)
`endif

`endif

@@ design/lbps_pkg.sv @@
// Types and constants of the LED bar pattern sequencer.
package lbps_pkg;

  localparam int unsigned COUNT_W   = 16;
  localparam int unsigned LED_W     = 8;
  localparam int unsigned MODE_W    = 3;
  localparam int unsigned MODE_SLOTS = 8;
  localparam int unsigned CFG_IDX_W = 2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_START_PERIOD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PERIOD_STEP  = 2'd1;

  localparam logic [COUNT_W-1:0] START_PERIOD_RST = 16'd15624;
  localparam logic [COUNT_W-1:0] PERIOD_STEP_RST  = 16'd3906;
  localparam logic [COUNT_W-1:0] PERIOD_MAX       = 16'hFFFF;

  // Command characters.
  localparam logic [7:0] CMD_UNLOCK = 8'h55;  // 'U'
  localparam logic [7:0] CMD_FASTER = 8'h41;  // 'A'
  localparam logic [7:0] CMD_SLOWER = 8'h42;  // 'B'
  // Digits '0' to '7' share these upper five bits.
  localparam logic [4:0] CMD_DIGIT_HI = 5'b00110;

  typedef enum logic [MODE_W-1:0] {
    MODE_HOLD        = 3'd0,
    MODE_INVERT      = 3'd1,
    MODE_COUNT_UP    = 3'd2,
    MODE_PULSE       = 3'd3,
    MODE_COUNT_DOWN  = 3'd4,
    MODE_ROTATE_LEFT = 3'd5,
    MODE_WALK_RIGHT  = 3'd6,
    MODE_FILL        = 3'd7
  } mode_e;

  // Default pattern of each mode, also the reset contents of the save slots.
  localparam logic [LED_W-1:0] DEFAULT_PAT [MODE_SLOTS] = '{
    8'hAA, 8'hAA, 8'h00, 8'h18, 8'hFF, 8'h01, 8'h7F, 8'h00
  };

  localparam logic [LED_W-1:0] PAT_TOP_BIT  = 8'b1000_0000;
  localparam logic [LED_W-1:0] PAT_LOW_BIT  = 8'b0000_0001;
  localparam logic [LED_W-1:0] PAT_WALK_END = 8'b1111_1110;
  localparam logic [LED_W-1:0] PAT_WALK_RST = 8'b0111_1111;
  localparam logic [LED_W-1:0] PAT_FULL     = 8'b1111_1111;

endpackage

@@ design/led_bar_pattern_sequencer.sv @@
// Top level of the LED bar pattern sequencer: command decode, step timer and pattern update.
//
// Usage: every slave beat is one event. s_axis_tuser = 0 marks a prescaled timer
// tick, s_axis_tuser = 1 marks a received command byte carried in s_axis_tdata.
// Each accepted beat yields exactly one master beat that reports the LED pattern,
// the active mode, the unlock flag and whether this beat advanced the pattern.
// The event is processed in the cycle it is accepted: the state registers and the
// result register load at the same edge, unless a configuration write takes the state
// registers; the result beat appears in the cycle after acceptance. One beat per cycle
// is sustained; the only limit is the single result register, which s_axis_tready frees
// whenever it is empty or being drained. When the receiver stalls, the result beat holds
// and s_axis_tready drops until it is taken, so no beat is lost or repeated.
// Reset clears pattern, mode, unlock flag and the tick counter, loads the period
// from its reset value and restores all eight save slots to the mode defaults.
// The configuration port writes start_period (index 0, also reloads the period)
// and period_step (index 1); writes are meant only while the block is idle.
`include "led_bar_pattern_sequencer_assert.svh"

module led_bar_pattern_sequencer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] cmd_byte
  input  logic        s_axis_tuser,   // [0] opcode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [7:0] led_pattern, [10:8] active_mode, [11] is_unlocked, [12] step_taken,
  // [15:13] zero
  output logic [15:0] m_axis_tdata,
  input  logic        cfg_we_i,
  input  logic [lbps_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [lbps_pkg::COUNT_W-1:0]   cfg_data_i
);

  // Architectural state.
  logic [lbps_pkg::COUNT_W-1:0] period_step_q;
  logic [lbps_pkg::COUNT_W-1:0] period_q, period_d;
  logic [lbps_pkg::COUNT_W-1:0] tick_q, tick_d;
  logic [lbps_pkg::LED_W-1:0]   led_q, led_d;
  lbps_pkg::mode_e              mode_q, mode_d;
  logic                         unlock_q, unlock_d;
  logic [lbps_pkg::LED_W-1:0]   saved_q [lbps_pkg::MODE_SLOTS];
  logic                         save_we;

  // Result register.
  logic                         out_valid_q;
  logic [lbps_pkg::LED_W-1:0]   out_led_q;
  lbps_pkg::mode_e              out_mode_q;
  logic                         out_unlock_q;
  logic                         out_step_q;

  logic                         in_acc;
  logic                         is_tick;
  logic                         match;
  logic                         step_d;
  logic [lbps_pkg::COUNT_W:0]   cmp_wide;
  logic [lbps_pkg::COUNT_W-1:0] cmp_val;
  logic [lbps_pkg::COUNT_W-1:0] faster_diff;
  logic [lbps_pkg::COUNT_W:0]   slower_sum;
  logic                         is_digit;
  lbps_pkg::mode_e              new_mode;

  // Next pattern on a compare match, by the rule of the active mode.
  function automatic logic [lbps_pkg::LED_W-1:0] advance(
    input logic [lbps_pkg::LED_W-1:0] pat,
    input lbps_pkg::mode_e            mode
  );
    logic [lbps_pkg::LED_W-1:0] base;
    base = pat;
    case (mode)
      lbps_pkg::MODE_INVERT:     advance = ~pat;
      lbps_pkg::MODE_COUNT_UP:   advance = pat + 8'd1;
      lbps_pkg::MODE_COUNT_DOWN: advance = pat - 8'd1;
      lbps_pkg::MODE_ROTATE_LEFT: begin
        advance = (pat == lbps_pkg::PAT_TOP_BIT) ? lbps_pkg::PAT_LOW_BIT
                                                 : {pat[6:0], 1'b0};
      end
      lbps_pkg::MODE_WALK_RIGHT: begin
        advance = (pat == lbps_pkg::PAT_WALK_END) ? lbps_pkg::PAT_WALK_RST
                                                  : {~1'b0, pat[7:1]};
      end
      lbps_pkg::MODE_FILL: begin
        if (pat == lbps_pkg::PAT_FULL) begin
          base = '0;
        end
        advance = {base[6:0], 1'b1};
      end
      default: advance = pat;
    endcase
  endfunction

  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign is_tick       = !s_axis_tuser;

  // Compare value: the period scaled by the mode's fraction in quarters,
  // truncated and saturated to the counter width.
  always_comb begin
    case (mode_q) inside
      lbps_pkg::MODE_COUNT_UP, lbps_pkg::MODE_PULSE, lbps_pkg::MODE_WALK_RIGHT:
        cmp_wide = {2'b00, period_q[lbps_pkg::COUNT_W-1:1]};
      lbps_pkg::MODE_COUNT_DOWN:
        cmp_wide = {3'b000, period_q[lbps_pkg::COUNT_W-1:2]};
      lbps_pkg::MODE_ROTATE_LEFT:
        cmp_wide = {1'b0, period_q} + {2'b00, period_q[lbps_pkg::COUNT_W-1:1]};
      default:
        cmp_wide = {1'b0, period_q};
    endcase
    cmp_val = cmp_wide[lbps_pkg::COUNT_W] ? lbps_pkg::PERIOD_MAX
                                          : cmp_wide[lbps_pkg::COUNT_W-1:0];
  end

  assign match       = (tick_q >= cmp_val);
  assign faster_diff = period_q - period_step_q;
  assign slower_sum  = {1'b0, period_q} + {1'b0, period_step_q};
  assign is_digit    = (s_axis_tdata[7:3] == lbps_pkg::CMD_DIGIT_HI);
  assign new_mode    = lbps_pkg::mode_e'(s_axis_tdata[2:0]);

  always_comb begin
    period_d = period_q;
    tick_d   = tick_q;
    led_d    = led_q;
    mode_d   = mode_q;
    unlock_d = unlock_q;
    save_we  = 1'b0;
    step_d   = 1'b0;
    if (is_tick) begin
      if (match) begin
        tick_d = '0;
        led_d  = advance(led_q, mode_q);
        step_d = 1'b1;
      end else begin
        tick_d = tick_q + 16'd1;
      end
    end else if (s_axis_tdata == lbps_pkg::CMD_UNLOCK) begin
      unlock_d = 1'b1;
    end else if (unlock_q) begin
      if (s_axis_tdata == lbps_pkg::CMD_FASTER) begin
        if (period_q > period_step_q) begin
          period_d = (faster_diff < period_step_q) ? period_step_q : faster_diff;
        end
      end else if (s_axis_tdata == lbps_pkg::CMD_SLOWER) begin
        period_d = slower_sum[lbps_pkg::COUNT_W] ? lbps_pkg::PERIOD_MAX
                                                 : slower_sum[lbps_pkg::COUNT_W-1:0];
      end else if (is_digit) begin
        if (new_mode == mode_q) begin
          // Reselecting the active mode reloads its default pattern.
          led_d = lbps_pkg::DEFAULT_PAT[s_axis_tdata[2:0]];
        end else begin
          save_we = 1'b1;
          led_d   = saved_q[s_axis_tdata[2:0]];
          mode_d  = new_mode;
        end
      end
    end
  end

  // State registers, including the configuration port.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_step_q <= lbps_pkg::PERIOD_STEP_RST;
      period_q      <= lbps_pkg::START_PERIOD_RST;
      tick_q        <= '0;
      led_q         <= '0;
      mode_q        <= lbps_pkg::MODE_HOLD;
      unlock_q      <= 1'b0;
      for (int i = 0; i < lbps_pkg::MODE_SLOTS; i++) begin
        saved_q[i] <= lbps_pkg::DEFAULT_PAT[i];
      end
    end else if (cfg_we_i) begin
      if (cfg_index_i == lbps_pkg::CFG_START_PERIOD) begin
        period_q <= cfg_data_i;
      end else if (cfg_index_i == lbps_pkg::CFG_PERIOD_STEP) begin
        period_step_q <= cfg_data_i;
      end
    end else if (in_acc) begin
      period_q <= period_d;
      tick_q   <= tick_d;
      led_q    <= led_d;
      mode_q   <= mode_d;
      unlock_q <= unlock_d;
      if (save_we) begin
        saved_q[mode_q] <= led_q;
      end
    end
  end

  // Result register: loads with each accepted beat, clears when drained.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_acc) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      out_led_q    <= led_d;
      out_mode_q   <= mode_d;
      out_unlock_q <= unlock_d;
      out_step_q   <= step_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'b000, out_step_q, out_unlock_q, out_mode_q, out_led_q};

  `LBPS_ASSERT_NEXT(a_unlock_sticks, unlock_q, unlock_q, "unlock flag cleared")
  `LBPS_ASSERT_NEXT(a_locked_holds, !unlock_q && !cfg_we_i,
                    $stable(period_q) && $stable(mode_q), "locked block changed period or mode")
  `LBPS_ASSERT_NEXT(a_cmd_no_step, in_acc && s_axis_tuser, !out_step_q,
                    "command beat reported a step")
  `LBPS_ASSERT_NEXT(a_match_clears, in_acc && is_tick && match && !cfg_we_i, tick_q == '0,
                    "tick counter not cleared on match")
  `LBPS_ASSERT_NEXT(a_result_valid, in_acc, out_valid_q, "accepted beat gave no result")

endmodule
